FILE: rtl/core/itt_pkg.sv
// Shared types and operation codes for the interval timer table.
// No dependencies; used by itt_cell and interval_timer_table.
`timescale 1ns / 1ps

package itt_pkg;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_CHECK  = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	localparam int TypeW = 4;
	localparam int TimeW = 32;

	// Command broadcast to every cell for the duration of one word.
	typedef struct packed {
		logic [1:0]       op;
		logic [TypeW-1:0] tmr_type;
	} cmd_t;

	// Running scan result handed from cell to cell.
	typedef struct packed {
		logic             act;
		logic             best_found;
		logic [TypeW-1:0] best_type;
		logic [TimeW-1:0] best_dl;
		logic             free_found;
	} carry_t;

	// Final update applied after the sweep.
	typedef struct packed {
		logic             wr_en;
		logic             clr_en;
		logic [TypeW-1:0] tmr_type;
		logic [TimeW-1:0] dl;
	} commit_t;

endpackage

FILE: rtl/core/itt_cell.sv
// One timer slot: valid mark, type and deadline, plus one stage of the scan chain.
// Depends on itt_pkg.
`timescale 1ns / 1ps

module itt_cell #(
	parameter int TIMER_SLOTS = 16,
	parameter int IDX         = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  itt_pkg::cmd_t                      cmd,
	input  itt_pkg::carry_t                    car_in,
	input  logic [$clog2(TIMER_SLOTS)-1:0]     best_idx_in,
	input  logic [$clog2(TIMER_SLOTS)-1:0]     free_idx_in,
	output itt_pkg::carry_t                    car_out,
	output logic [$clog2(TIMER_SLOTS)-1:0]     best_idx_out,
	output logic [$clog2(TIMER_SLOTS)-1:0]     free_idx_out,
	input  itt_pkg::commit_t                   commit,
	input  logic [$clog2(TIMER_SLOTS)-1:0]     wr_idx,
	input  logic [$clog2(TIMER_SLOTS)-1:0]     clr_idx
);
	import itt_pkg::*;

	localparam int IW = $clog2(TIMER_SLOTS);
	localparam logic [IW-1:0] MyIdx = IW'(IDX);

	logic             valid_q;
	logic [TypeW-1:0] type_q;
	logic [TimeW-1:0] deadline_q;

	carry_t          car_q;
	logic [IW-1:0]   best_idx_q;
	logic [IW-1:0]   free_idx_q;

	logic   type_hit;
	logic   cand;
	logic   take;
	logic   take_free;
	logic   cancel_hit;
	carry_t car_d;

	always_comb begin
		type_hit   = valid_q && (type_q == cmd.tmr_type);
		// check looks at every live slot, query only at its own type
		cand       = valid_q && ((cmd.op != OP_QUERY) || (type_q == cmd.tmr_type));
		take       = car_in.act && cand &&
			(!car_in.best_found || (deadline_q < car_in.best_dl));
		take_free  = car_in.act && !car_in.free_found && !valid_q;
		cancel_hit = car_in.act && (cmd.op == OP_CANCEL) && type_hit;

		car_d = car_in;
		if (take) begin
			car_d.best_found = 1'b1;
			car_d.best_type  = type_q;
			car_d.best_dl    = deadline_q;
		end
		if (take_free) begin
			car_d.free_found = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_q <= '0;
		end else begin
			car_q <= car_d;
		end
	end

	always_ff @(posedge clk) begin
		best_idx_q <= take ? MyIdx : best_idx_in;
		free_idx_q <= take_free ? MyIdx : free_idx_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (commit.wr_en && (wr_idx == MyIdx)) begin
			valid_q <= 1'b1;
		end else if (cancel_hit || (commit.clr_en && (clr_idx == MyIdx))) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit.wr_en && (wr_idx == MyIdx)) begin
			type_q     <= commit.tmr_type;
			deadline_q <= commit.dl;
		end
	end

	assign car_out      = car_q;
	assign best_idx_out = best_idx_q;
	assign free_idx_out = free_idx_q;

endmodule

FILE: rtl/core/interval_timer_table.sv
// Top level of the interval timer table: control, chain of slot cells, result register.
// Depends on itt_pkg and itt_cell.
//
//   channel | handshake           | words
//   --------+---------------------+--------------------------------------------------
//   in      | in_valid / in_ready | operation, timer_type, delay_seconds, now_time
//   out     | out_valid/out_ready | fired_type, deadline, status
//
// One word at a time: a scan token walks the chain of TIMER_SLOTS cells, one cell per
// cycle; the result is registered at the end of the chain and in_ready returns with it.
// The slot update (add, check removal) is applied in the cycle the result is loaded.
// A result that is not taken holds the next word in its final state; in_ready stays low.
// Reset clears all valid marks at once; no clearing pass is needed.
`timescale 1ns / 1ps

module interval_timer_table #(
	parameter int TIMER_SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 operation,
	input  logic [itt_pkg::TypeW-1:0]  timer_type,
	input  logic [itt_pkg::TimeW-1:0]  delay_seconds,
	input  logic [itt_pkg::TimeW-1:0]  now_time,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [itt_pkg::TypeW-1:0]  fired_type,
	output logic [itt_pkg::TimeW-1:0]  deadline,
	output logic                       status
);
	import itt_pkg::*;

	localparam int IW = $clog2(TIMER_SLOTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       st_q;
	logic             start_q;
	cmd_t             cmd_q;
	logic [TimeW-1:0] now_q;
	logic [TimeW-1:0] sum_q;

	carry_t        fin_q;
	logic [IW-1:0] fin_best_idx_q;
	logic [IW-1:0] fin_free_idx_q;

	logic             out_valid_q;
	logic [TypeW-1:0] fired_q;
	logic [TimeW-1:0] dl_q;
	logic             status_q;

	carry_t        car  [0:TIMER_SLOTS];
	logic [IW-1:0] bidx [0:TIMER_SLOTS];
	logic [IW-1:0] fidx [0:TIMER_SLOTS];

	logic           in_acc;
	logic           finish;
	logic           due;
	logic [TimeW:0] sum_full;
	commit_t        commit;

	assign in_ready = (st_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign finish   = (st_q == ST_DONE) && (!out_valid_q || out_ready);
	assign due      = fin_q.best_found && (fin_q.best_dl <= now_q);
	assign sum_full = {1'b0, now_time} + {1'b0, delay_seconds};

	always_comb begin
		commit          = '0;
		commit.tmr_type = cmd_q.tmr_type;
		commit.dl       = sum_q;
		if (finish) begin
			commit.wr_en  = (cmd_q.op == OP_ADD) && fin_q.free_found;
			commit.clr_en = (cmd_q.op == OP_CHECK) && due;
		end
	end

	assign car[0]  = '{act: start_q, best_found: 1'b0, best_type: '0,
		best_dl: '0, free_found: 1'b0};
	assign bidx[0] = '0;
	assign fidx[0] = '0;

	for (genvar k = 0; k < TIMER_SLOTS; k++) begin : g_cell
		itt_cell #(
			.TIMER_SLOTS(TIMER_SLOTS),
			.IDX        (k)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd_q),
			.car_in      (car[k]),
			.best_idx_in (bidx[k]),
			.free_idx_in (fidx[k]),
			.car_out     (car[k+1]),
			.best_idx_out(bidx[k+1]),
			.free_idx_out(fidx[k+1]),
			.commit      (commit),
			.wr_idx      (fin_free_idx_q),
			.clr_idx     (fin_best_idx_q)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= in_acc;
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) st_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (car[TIMER_SLOTS].act) st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (finish) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q.op       <= operation;
			cmd_q.tmr_type <= timer_type;
			now_q          <= now_time;
			// saturate the deadline on overflow
			sum_q          <= sum_full[TimeW] ? '1 : sum_full[TimeW-1:0];
		end
		if (car[TIMER_SLOTS].act) begin
			fin_q          <= car[TIMER_SLOTS];
			fin_best_idx_q <= bidx[TIMER_SLOTS];
			fin_free_idx_q <= fidx[TIMER_SLOTS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			fired_q  <= ((cmd_q.op == OP_CHECK) && due) ? fin_q.best_type : '0;
			dl_q     <= ((cmd_q.op == OP_QUERY) && fin_q.best_found) ? fin_q.best_dl : '0;
			status_q <= (cmd_q.op == OP_ADD) && !fin_q.free_found;
		end
	end

	assign out_valid  = out_valid_q;
	assign fired_type = fired_q;
	assign deadline   = dl_q;
	assign status     = status_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a word while busy");

	a_commit_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(commit.wr_en && commit.clr_en))
		else $error("slot write and clear in the same cycle");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		car[TIMER_SLOTS].act |-> st_q == ST_SCAN)
		else $error("scan token left the chain outside a scan");

	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> fired_type == '0 && deadline == '0)
		else $error("refused add reports a type or deadline");
`endif

endmodule
